/* rtl/core/ssis_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the sorted set intersect / subtract block.
// No dependencies; every other file imports this package.
package ssis_pkg;

  localparam int VALUE_W = 32;
  localparam int CMD_W   = 2;
  localparam int OP_W    = 2;
  localparam int COUNT_W = 7;

  // Command queue between the front and the back
  localparam int QDEPTH  = 2;
  localparam int QIDX_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN         = 2'd2;

  localparam logic [OP_W-1:0] OP_ISECT    = 2'd0;
  localparam logic [OP_W-1:0] OP_COUNT    = 2'd1;
  localparam logic [OP_W-1:0] OP_SUBTRACT = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD_A,
    KIND_LOAD_B,
    KIND_RUN
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic [OP_W-1:0]     operation;
    logic                bound_enable;
    logic [VALUE_W-1:0]  bound_limit;
  } q_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CMP,
    S_FINISH
  } back_state_t;

endpackage

/* rtl/core/ssis_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
// Depends on ssis_pkg for field widths.
interface ssis_in_if;
  import ssis_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [VALUE_W-1:0]  value;
  logic [OP_W-1:0]     operation;
  logic                bound_enable;
  logic [VALUE_W-1:0]  bound_limit;

  modport source (output valid, cmd, value, operation, bound_enable, bound_limit,
                  input ready);
  modport sink   (input valid, cmd, value, operation, bound_enable, bound_limit,
                  output ready);
endinterface

interface ssis_out_if;
  import ssis_pkg::*;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  element;
  logic                has_element;
  logic [COUNT_W-1:0]  result_count;
  logic                is_last;
  logic                overflow;

  modport source (output valid, element, has_element, result_count, is_last, overflow,
                  input ready);
  modport sink   (input valid, element, has_element, result_count, is_last, overflow,
                  output ready);
endinterface

/* rtl/core/ssis_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies the command and queues it.
// Depends on ssis_pkg and ssis_in_if.
module ssis_front (
  input  logic               clk,
  input  logic               rst_n,
  ssis_in_if.sink            in_chan,
  output ssis_pkg::q_entry_t q_entry,
  output logic               q_valid,
  input  logic               q_pop
);
  import ssis_pkg::*;

  q_entry_t            fifo_r [QDEPTH];
  logic [QIDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   fill_r, fill_nxt;
  logic                known;
  logic                push;
  q_entry_t            entry;

  always_comb begin
    entry.value        = in_chan.value;
    entry.operation    = in_chan.operation;
    entry.bound_enable = in_chan.bound_enable;
    entry.bound_limit  = in_chan.bound_limit;
    entry.kind         = KIND_RUN;
    known              = 1'b1;
    unique case (in_chan.cmd)
      CMD_LOAD_FIRST:  entry.kind = KIND_LOAD_A;
      CMD_LOAD_SECOND: entry.kind = KIND_LOAD_B;
      CMD_RUN:         entry.kind = KIND_RUN;
      default:         known = 1'b0; // drop unknown commands
    endcase
  end

  assign in_chan.ready = (fill_r != QCNT_W'(QDEPTH));
  assign push          = in_chan.valid && in_chan.ready && known;
  assign q_valid       = (fill_r != '0);
  assign q_entry       = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = (rd_ptr_r == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !(q_pop && q_valid)) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && q_pop && q_valid) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= entry;
    end
  end

endmodule

/* rtl/core/ssis_back.sv */
`timescale 1ns / 1ps
// Back end: list storage, load execution, merge walk and output register.
// Depends on ssis_pkg and ssis_out_if; fed by ssis_front.
module ssis_back #(
  parameter int MAX_LEN  = 64,
  parameter int ID_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ssis_pkg::q_entry_t q_entry,
  input  logic               q_valid,
  output logic               q_pop,
  ssis_out_if.source         out_chan
);
  import ssis_pkg::*;

  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int STORE_W = (ID_WIDTH < VALUE_W) ? ID_WIDTH : VALUE_W;

  logic [STORE_W-1:0] mem_a [MAX_LEN];
  logic [STORE_W-1:0] mem_b [MAX_LEN];

  back_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]   cnt_b_r, cnt_b_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic               bnd_en_r, bnd_en_nxt;
  logic [VALUE_W-1:0] bnd_r, bnd_nxt;
  logic               ovf_snap_r, ovf_snap_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [STORE_W-1:0] pend_v_r, pend_v_nxt;
  logic [STORE_W-1:0] a_rd_r, b_rd_r;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_elem_r;
  logic               out_has_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic               out_last_r;
  logic               out_ovf_r;

  logic               slot_free;
  logic               push;
  logic [STORE_W-1:0] push_elem;
  logic               push_has;
  logic               push_last;
  logic               we_a, we_b, re;
  logic [VALUE_W-1:0] a_ext, b_ext;
  logic               j_ok, b_lt, b_eq, stop, hit, emit_op;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign a_ext     = VALUE_W'(a_rd_r);
  assign b_ext     = VALUE_W'(b_rd_r);
  assign j_ok      = (j_r < cnt_b_r);
  assign b_lt      = j_ok && (b_ext < a_ext);
  assign b_eq      = j_ok && (b_ext == a_ext);
  assign stop      = bnd_en_r && (a_ext >= bnd_r);
  assign hit       = (op_r == OP_SUBTRACT) ? !b_eq : b_eq;
  assign emit_op   = (op_r != OP_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    n_nxt          = n_r;
    op_nxt         = op_r;
    bnd_en_nxt     = bnd_en_r;
    bnd_nxt        = bnd_r;
    ovf_snap_nxt   = ovf_snap_r;
    pend_valid_nxt = pend_valid_r;
    pend_v_nxt     = pend_v_r;
    q_pop          = 1'b0;
    we_a           = 1'b0;
    we_b           = 1'b0;
    re             = 1'b0;
    push           = 1'b0;
    push_elem      = pend_v_r;
    push_has       = 1'b1;
    push_last      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_entry.kind)
            KIND_LOAD_A: begin
              if (cnt_a_r < CNT_W'(MAX_LEN)) begin
                we_a      = 1'b1;
                cnt_a_nxt = cnt_a_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            KIND_LOAD_B: begin
              if (cnt_b_r < CNT_W'(MAX_LEN)) begin
                we_b      = 1'b1;
                cnt_b_nxt = cnt_b_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            KIND_RUN: begin
              op_nxt         = q_entry.operation;
              bnd_en_nxt     = q_entry.bound_enable;
              bnd_nxt        = q_entry.bound_limit;
              ovf_snap_nxt   = ovf_r;
              i_nxt          = '0;
              j_nxt          = '0;
              n_nxt          = '0;
              pend_valid_nxt = 1'b0;
              if (q_entry.operation == OP_ISECT || q_entry.operation == OP_COUNT ||
                  q_entry.operation == OP_SUBTRACT) begin
                state_nxt = S_FETCH;
              end else begin
                state_nxt = S_FINISH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        if (i_r < cnt_a_r) begin
          re        = 1'b1;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_CMP: begin
        priority if (stop) begin
          state_nxt = S_FINISH;
        end else if (b_lt) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_FETCH;
        end else if (hit && emit_op && pend_valid_r && !slot_free) begin
          // hold until the output register can take the pending result
          state_nxt = S_CMP;
        end else begin
          if (b_eq) begin
            j_nxt = j_r + 1'b1;
          end
          i_nxt = i_r + 1'b1;
          if (hit) begin
            n_nxt = n_r + 1'b1;
            if (emit_op) begin
              push           = pend_valid_r;
              pend_v_nxt     = a_rd_r;
              pend_valid_nxt = 1'b1;
            end
          end
          state_nxt = S_FETCH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          push      = 1'b1;
          push_elem = pend_valid_r ? pend_v_r : '0;
          push_has  = pend_valid_r;
          push_last = 1'b1;
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      ovf_r        <= ovf_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    n_r        <= n_nxt;
    op_r       <= op_nxt;
    bnd_en_r   <= bnd_en_nxt;
    bnd_r      <= bnd_nxt;
    ovf_snap_r <= ovf_snap_nxt;
    pend_v_r   <= pend_v_nxt;
    if (push) begin
      out_elem_r <= VALUE_W'(push_elem);
      out_has_r  <= push_has;
      out_cnt_r  <= COUNT_W'(n_r);
      out_last_r <= push_last;
      out_ovf_r  <= ovf_snap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[cnt_a_r[IDX_W-1:0]] <= q_entry.value[STORE_W-1:0];
    end
    if (re) begin
      a_rd_r <= mem_a[i_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[cnt_b_r[IDX_W-1:0]] <= q_entry.value[STORE_W-1:0];
    end
    if (re) begin
      b_rd_r <= mem_b[j_r[IDX_W-1:0]];
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.element      = out_elem_r;
  assign out_chan.has_element  = out_has_r;
  assign out_chan.result_count = out_cnt_r;
  assign out_chan.is_last      = out_last_r;
  assign out_chan.overflow     = out_ovf_r;

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (i_r < cnt_a_r))
    else $error("compare issued past the end of the first list");

  a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (j_r <= cnt_b_r))
    else $error("second list index ran beyond its fill");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && slot_free) |=> (cnt_a_r == '0 && cnt_b_r == '0 && !ovf_r))
    else $error("lists not cleared at the end of a run");

  a_elem_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_has_r) |-> (out_cnt_r != '0))
    else $error("result id carried with a zero count");

  a_no_push_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> slot_free)
    else $error("output register overwritten while held");

endmodule

/* rtl/core/sorted_set_intersect_subtract_top.sv */
`timescale 1ns / 1ps
// Loads: one transaction a cycle while the queue has room and the back end is idle; each
// is executed as it leaves the queue. Run: each merge step reads both lists, then compares,
// advancing the second list index, or the first (and the second too on a match).
// Results leave through one output register; the walk stalls only when it is held.
// Reset (rst_n low, synchronous) empties both lists, the queue and the overflow flag.
module sorted_set_intersect_subtract_top #(
  parameter int MAX_LEN  = 64,
  parameter int ID_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ssis_in_if.sink     in_chan,
  ssis_out_if.source  out_chan
);
  import ssis_pkg::*;

  q_entry_t q_entry;
  logic     q_valid;
  logic     q_pop;

  ssis_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_entry (q_entry),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  ssis_back #(
    .MAX_LEN  (MAX_LEN),
    .ID_WIDTH (ID_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_entry  (q_entry),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

/* tb/tb_sorted_set_intersect_subtract_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sorted_set_intersect_subtract_top: loads id lists, runs merges
// and compares every result transaction against an in-bench model of the merge.
// Depends on ssis_pkg, ssis_in_if / ssis_out_if and the top-level RTL.
module tb_sorted_set_intersect_subtract_top;
  import ssis_pkg::*;

  localparam int LIST_DEPTH  = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 4 * LIST_DEPTH + 40;
  localparam int CYCLE_LIMIT = 900000;
  // Load/run transaction count at which the random test stops adding sets
  localparam int ITEM_TARGET = 190;

  // Codes the block must ignore or treat as an empty run
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [OP_W-1:0]  OP_UNUSED  = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [OP_W-1:0]    op;
    logic               bnd;
    logic [VALUE_W-1:0] ub;
  } ssis_req_t;

  typedef struct {
    logic [VALUE_W-1:0] element;
    logic               has_element;
    logic [COUNT_W-1:0] result_count;
    logic               is_last;
    logic               overflow;
  } ssis_res_t;

  logic clk = 1'b0;
  logic rst_n;

  ssis_in_if  in_if ();
  ssis_out_if out_if ();

  sorted_set_intersect_subtract_top #(
    .MAX_LEN  (LIST_DEPTH),
    .ID_WIDTH (VALUE_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #1 clk = ~clk;

  // Model state
  logic [VALUE_W-1:0] first_ids  [LIST_DEPTH];
  logic [VALUE_W-1:0] second_ids [LIST_DEPTH];
  int                 first_len;
  int                 second_len;
  bit                 drop_seen;
  ssis_res_t          pending_results [$];

  int  mismatches;
  int  items_sent;
  int  runs_sent;
  int  dropped_runs;
  int  results_checked;
  int  cycle_count;

  // Sender and receiver behaviour
  bit  sender_idles;
  int  burst_left;
  bit  rcv_stalls;
  int  stall_run;
  int  hold_req;
  int  hold_seen;
  int  hold_left;

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic merge_predict(input ssis_req_t r);
    ssis_res_t          res;
    logic [VALUE_W-1:0] v;
    int                 n;
    int                 j;
    int                 k;
    bit                 found;
    bit                 hit;
    bit                 drop_now;
    n = 0;
    j = 0;
    k = 0;
    case (r.cmd)
      CMD_LOAD_FIRST: begin
        if (first_len < LIST_DEPTH) begin
          first_ids[first_len] = r.value;
          first_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      CMD_LOAD_SECOND: begin
        if (second_len < LIST_DEPTH) begin
          second_ids[second_len] = r.value;
          second_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      CMD_RUN: begin
        drop_now = drop_seen;
        runs_sent++;
        if (drop_now) dropped_runs++;
        if (r.op != OP_UNUSED) begin
          for (int i = 0; i < first_len; i++) begin
            v = first_ids[i];
            if (r.bnd && v >= r.ub) break;
            while (j < second_len && second_ids[j] < v) j++;
            found = (j < second_len) && (second_ids[j] == v);
            if (found) j++;
            hit = (r.op == OP_SUBTRACT) ? !found : found;
            if (hit) begin
              n++;
              if (r.op != OP_COUNT) begin
                res = '{v, 1'b1, COUNT_W'(n), 1'b0, drop_now};
                pending_results.push_back(res);
                k++;
              end
            end
          end
        end
        if (r.op == OP_COUNT) begin
          res = '{'0, 1'b0, COUNT_W'(n), 1'b1, drop_now};
          pending_results.push_back(res);
        end else if (k == 0) begin
          res = '{'0, 1'b0, '0, 1'b1, drop_now};
          pending_results.push_back(res);
        end else begin
          pending_results[pending_results.size() - 1].is_last = 1'b1;
        end
        first_len  = 0;
        second_len = 0;
        drop_seen  = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic ssis_req_t mk_req(input logic [CMD_W-1:0] cmd,
                                       input logic [VALUE_W-1:0] value,
                                       input logic [OP_W-1:0] op, input logic bnd,
                                       input logic [VALUE_W-1:0] ub);
    ssis_req_t r;
    r = '{cmd, value, op, bnd, ub};
    return r;
  endfunction

  // Hold valid low for a number of cycles
  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_if.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_item(input ssis_req_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_idles) pause_input($urandom_range(1, 6));
    end
    burst_left--;
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.cmd          <= r.cmd;
    in_if.value        <= r.value;
    in_if.operation    <= r.op;
    in_if.bound_enable <= r.bnd;
    in_if.bound_limit  <= r.ub;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (r.cmd != CMD_UNUSED) items_sent++;
    merge_predict(r);
  endtask

  task automatic load_id(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] v);
    send_item(mk_req(cmd, v, OP_W'($urandom), 1'($urandom), $urandom));
  endtask

  task automatic run_merge(input logic [OP_W-1:0] op, input logic bnd,
                           input logic [VALUE_W-1:0] ub);
    send_item(mk_req(CMD_RUN, $urandom, op, bnd, ub));
  endtask

  // Result checker
  ssis_res_t want;
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result element", out_if.element, '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_if.element !== want.element)
          report_mismatch("element", out_if.element, want.element);
        if (out_if.has_element !== want.has_element)
          report_mismatch("has_element", VALUE_W'(out_if.has_element),
                          VALUE_W'(want.has_element));
        if (out_if.result_count !== want.result_count)
          report_mismatch("result_count", VALUE_W'(out_if.result_count),
                          VALUE_W'(want.result_count));
        if (out_if.is_last !== want.is_last)
          report_mismatch("is_last", VALUE_W'(out_if.is_last), VALUE_W'(want.is_last));
        if (out_if.overflow !== want.overflow)
          report_mismatch("overflow", VALUE_W'(out_if.overflow), VALUE_W'(want.overflow));
      end
    end
  end

  // Receiver: optional random stall runs, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!rcv_stalls) begin
      out_if.ready <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run    <= stall_run - 1;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_run    <= $urandom_range(0, 7);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_empty_run;
    run_merge(OP_ISECT, 1'b0, '0);
  endtask

  task automatic test_count_with_bound;
    load_id(CMD_LOAD_FIRST, 32'h0000_0000);
    load_id(CMD_LOAD_FIRST, 32'h0000_0007);
    load_id(CMD_LOAD_FIRST, 32'hFFFF_FFFF);
    load_id(CMD_LOAD_SECOND, 32'h0000_0007);
    load_id(CMD_LOAD_SECOND, 32'hFFFF_FFFF);
    run_merge(OP_COUNT, 1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_subtract;
    load_id(CMD_LOAD_FIRST, 32'd3);
    load_id(CMD_LOAD_FIRST, 32'd8);
    load_id(CMD_LOAD_FIRST, 32'd12);
    load_id(CMD_LOAD_SECOND, 32'd8);
    run_merge(OP_SUBTRACT, 1'b0, '0);
  endtask

  task automatic test_ignored_cmd_and_bad_op;
    send_item(mk_req(CMD_UNUSED, 32'hFFFF_FFFF, OP_UNUSED, 1'b1, 32'hFFFF_FFFF));
    load_id(CMD_LOAD_FIRST, 32'd1);
    load_id(CMD_LOAD_SECOND, 32'd1);
    run_merge(OP_UNUSED, 1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_bound;
    load_id(CMD_LOAD_FIRST, 32'd0);
    run_merge(OP_ISECT, 1'b1, 32'd0);
  endtask

  task automatic test_unordered;
    load_id(CMD_LOAD_FIRST, 32'd9);
    load_id(CMD_LOAD_FIRST, 32'd2);
    load_id(CMD_LOAD_SECOND, 32'd2);
    load_id(CMD_LOAD_SECOND, 32'd9);
    run_merge(OP_ISECT, 1'b0, '0);
  endtask

  // Overfill both lists, then intersect them whole for a full-length result
  task automatic test_full_lists;
    for (int i = 0; i < LIST_DEPTH + 1; i++)
      load_id(CMD_LOAD_FIRST, 32'hFFFF_FE00 + 32'(3 * i));
    for (int i = 0; i < LIST_DEPTH + 1; i++)
      load_id(CMD_LOAD_SECOND, 32'hFFFF_FE00 + 32'(3 * i));
    run_merge(OP_ISECT, 1'b0, '0);
  endtask

  // Stop the receiver for a long stretch while runs keep arriving
  task automatic test_backpressure;
    sender_idles = 1'b0;
    rcv_stalls   = 1'b0;
    hold_req++;
    for (int r = 0; r < 2; r++) begin
      for (int i = 0; i < 6; i++) load_id(CMD_LOAD_FIRST, 32'(10 * i + r));
      for (int i = 0; i < 6; i += 2) load_id(CMD_LOAD_SECOND, 32'(10 * i + r));
      run_merge(r[0] ? OP_SUBTRACT : OP_ISECT, 1'b0, '0);
    end
  endtask

  task automatic random_set(input int pool_max, input bit ordered);
    logic [VALUE_W-1:0] a_ids [$];
    logic [VALUE_W-1:0] b_ids [$];
    logic [VALUE_W:0]   v;
    logic [VALUE_W-1:0] step;
    logic [VALUE_W-1:0] ub;
    logic [OP_W-1:0]    op;
    int                 pool;
    int                 pick;
    int                 ia;
    int                 ib;
    pool = $urandom_range(0, pool_max);
    if ($urandom_range(0, 1) == 0) v = {1'b0, $urandom};
    else v = (VALUE_W + 1)'($urandom_range(0, 40));
    for (int i = 0; i < pool; i++) begin
      if (ordered) begin
        if (i != 0) begin
          step = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 32'h00FF_FFFF : 8);
          v    = v + {1'b0, step};
        end
        if (v[VALUE_W]) break;
      end else begin
        v = {1'b0, $urandom};
      end
      pick = $urandom_range(0, 2);
      if (pick != 1) a_ids.push_back(v[VALUE_W-1:0]);
      if (pick != 0) b_ids.push_back(v[VALUE_W-1:0]);
    end
    ia = 0;
    ib = 0;
    // Interleave the two lists' loads in random order
    while (ia < a_ids.size() || ib < b_ids.size()) begin
      if (ib >= b_ids.size() || (ia < a_ids.size() && $urandom_range(0, 1) == 1)) begin
        load_id(CMD_LOAD_FIRST, a_ids[ia]);
        ia++;
      end else begin
        load_id(CMD_LOAD_SECOND, b_ids[ib]);
        ib++;
      end
      if ($urandom_range(0, 29) == 0)
        send_item(mk_req(CMD_UNUSED, $urandom, OP_W'($urandom), 1'($urandom), $urandom));
    end
    if ($urandom_range(0, 9) == 0) op = OP_UNUSED;
    else op = OP_W'($urandom_range(0, 2));
    if (a_ids.size() != 0 && $urandom_range(0, 1) == 1)
      ub = a_ids[$urandom_range(0, a_ids.size() - 1)] + 32'($urandom_range(0, 1));
    else
      ub = $urandom;
    run_merge(op, 1'($urandom), ub);
  endtask

  task automatic test_random;
    int pick;
    while (items_sent < ITEM_TARGET) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      rcv_stalls   = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 15) random_set(8, 1'b0);
      else random_set(12, 1'b1);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.cmd          = '0;
    in_if.value        = '0;
    in_if.operation    = '0;
    in_if.bound_enable = 1'b0;
    in_if.bound_limit  = '0;
    out_if.ready       = 1'b0;
    first_len          = 0;
    second_len         = 0;
    drop_seen          = 1'b0;
    mismatches         = 0;
    items_sent         = 0;
    runs_sent          = 0;
    dropped_runs       = 0;
    results_checked    = 0;
    cycle_count        = 0;
    sender_idles       = 1'b1;
    burst_left         = 0;
    rcv_stalls         = 1'b1;
    stall_run          = 0;
    hold_req           = 0;
    hold_seen          = 0;
    hold_left          = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_run();
    test_count_with_bound();
    test_subtract();
    test_ignored_cmd_and_bad_op();
    test_zero_bound();
    test_unordered();
    test_full_lists();
    test_backpressure();
    test_random();

    pause_input(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d load/run transactions (%0d runs, %0d after dropped loads),",
             items_sent, runs_sent, dropped_runs);
    $display("checked %0d results over empty and full lists, all merge kinds, bounds,",
             results_checked);
    $display("ignored codes and a long hold-off.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sorted_set_intersect_subtract_top.f */
rtl/core/ssis_pkg.sv
rtl/core/ssis_if.sv
rtl/core/ssis_front.sv
rtl/core/ssis_back.sv
rtl/core/sorted_set_intersect_subtract_top.sv
tb/tb_sorted_set_intersect_subtract_top.sv
